// File: hw/rtl/hsps_pkg.sv
`default_nettype none
package hsps_pkg;

	typedef enum logic [5:0] {
		PH_HDR, PH_PROF, PH_CONS, PH_LEVEL, PH_SPSID, PH_CHROMA, PH_RESID,
		PH_BDL, PH_BDC, PH_BYPASS, PH_SMP, PH_LISTFLAG, PH_DELTA, PH_LOG2FN,
		PH_POCTYPE, PH_LOG2POC, PH_DPAZ, PH_ONRP, PH_OTTB, PH_NCYCLE, PH_OFFREF,
		PH_MAXREF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_FMO, PH_MBAFF, PH_DIRECT,
		PH_CROPF, PH_CROPL, PH_CROPR, PH_CROPT, PH_CROPB, PH_VUI, PH_ARFLAG,
		PH_ARIDC, PH_SARW, PH_SARH, PH_OVFLAG, PH_OVAPP, PH_VSFLAG, PH_VFMT,
		PH_FULLR, PH_CDFLAG, PH_CPRIM, PH_TRANS, PH_MATRIX, PH_CLFLAG, PH_CLTOP,
		PH_CLBOT, PH_TIMFLAG, PH_TICK, PH_SCALE, PH_DONE, PH_DONE_TIMED
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_SHORT = 2'd1, ST_ZERO_TICK = 2'd2
	} status_t;

	// queue entry between the byte front end and the bit parser
	typedef struct packed {
		logic [7:0] data;
		logic       keep;
		logic       last;
	} entry_t;

	localparam logic [7:0] EMU_BYTE = 8'h03;
	localparam logic [7:0] LIST_LIMIT = 8'd224;

	function automatic logic [5:0] fixed_len(input phase_t ph);
		unique case (ph)
			PH_HDR, PH_PROF, PH_CONS, PH_LEVEL, PH_ARIDC, PH_CPRIM, PH_TRANS,
			PH_MATRIX: fixed_len = 6'd8;
			PH_SARW, PH_SARH: fixed_len = 6'd16;
			PH_VFMT: fixed_len = 6'd3;
			PH_TICK, PH_SCALE: fixed_len = 6'd32;
			PH_RESID, PH_BYPASS, PH_SMP, PH_LISTFLAG, PH_DPAZ, PH_GAPS, PH_FMO,
			PH_MBAFF, PH_DIRECT, PH_CROPF, PH_VUI, PH_ARFLAG, PH_OVFLAG,
			PH_OVAPP, PH_VSFLAG, PH_FULLR, PH_CDFLAG, PH_CLFLAG,
			PH_TIMFLAG: fixed_len = 6'd1;
			default: fixed_len = 6'd0;
		endcase
	endfunction

	function automatic logic high_profile(input logic [7:0] p);
		high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
			(p == 8'd244) || (p == 8'd44) || (p == 8'd83) || (p == 8'd86) ||
			(p == 8'd118);
	endfunction

	// first position after the scaling list holding position p (9 bits)
	function automatic logic [8:0] list_end(input logic [7:0] p);
		logic [7:0] q;
		q = p - 8'd96;
		if (p < 8'd96)
			list_end = {1'b0, p[7:4], 4'b0} + 9'd16;
		else
			list_end = 9'd96 + {1'b0, q[7:6], 6'b0} + 9'd64;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hsps_front.sv
`default_nettype none
// Accept bytes, mark emulation prevention bytes for dropping, push to queue.
module hsps_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            valid,
	output logic                 ready,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	output logic                 push,
	output hsps_pkg::entry_t     push_entry,
	input  wire logic            full
);
	logic [1:0] zero_run_q;
	logic       emu;

	assign ready = !full;
	assign push = valid && ready;
	assign emu = (zero_run_q == 2'd2) && (data_byte == hsps_pkg::EMU_BYTE);
	assign push_entry.data = data_byte;
	assign push_entry.keep = !emu;
	assign push_entry.last = last_byte;

	// track the zero run; the last byte restarts it for the next unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= 2'd0;
		end else if (push) begin
			if (last_byte || emu)
				zero_run_q <= 2'd0;
			else if (data_byte == 8'd0)
				zero_run_q <= (zero_run_q == 2'd2) ? 2'd2 : zero_run_q + 2'd1;
			else
				zero_run_q <= 2'd0;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/hsps_fifo.sv
`default_nettype none
// Two-entry queue between front end and parser.
module hsps_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hsps_pkg::entry_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output hsps_pkg::entry_t      pop_entry,
	output logic                  not_empty
);
	hsps_pkg::entry_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/hsps_parse.sv
`default_nettype none
// Bit-serial parser: one bit per cycle while a kept byte is held, then the result computation steps.
module hsps_parse #(
	parameter int CODE_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hsps_pkg::entry_t entry,
	input  wire logic             not_empty,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [15:0]           pic_width,
	output logic [15:0]           pic_height,
	output logic [7:0]            profile_code,
	output logic [7:0]            level_code,
	output logic [31:0]           frame_rate,
	output logic                  timing_present,
	output logic [1:0]            parse_status
);
	typedef enum logic [2:0] {
		S_IDLE, S_BITS, S_CALC, S_DIV, S_OUT
	} pstate_t;

	localparam logic [CODE_BITS-1:0] CMASK = '1;

	pstate_t          state_q, state_d;
	hsps_pkg::phase_t ph_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [2:0]  bidx_q;
	logic [5:0]  bit_counter_q, golomb_zeros_q;
	logic [31:0] field_accum_q;
	logic [7:0]  loop_counter_q, scale_last_q, scale_next_q;
	logic [15:0] width_mbs_q, height_units_q, profile_level_q;
	logic [31:0] crop_h_q, crop_v_q, tick_q, scale_q;
	logic        frame_only_q;
	logic [5:0]  div_cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [32:0] divisor;

	logic        bit_in, take;
	logic [5:0]  flen;
	logic        fin;
	logic [31:0] fin_v;
	logic [31:0] acc_sh;

	assign bit_in = byte_q[bidx_q];
	assign flen = hsps_pkg::fixed_len(ph_q);
	assign acc_sh = {field_accum_q[30:0], bit_in};
	assign take = (state_q == S_BITS) && (ph_q < hsps_pkg::PH_DONE);
	assign divisor = {tick_q, 1'b0};

	// decide when a field completes and its value
	always_comb begin
		fin = 1'b0;
		fin_v = 32'd0;
		if (take) begin
			if (flen != 6'd0) begin
				fin = (bit_counter_q + 6'd1 >= flen);
				fin_v = acc_sh;
			end else if (bit_counter_q == 6'd0) begin
				fin = bit_in && (golomb_zeros_q == 6'd0);
			end else if (bit_counter_q == 6'd1) begin
				fin = 1'b1;
				fin_v = (acc_sh & 32'(CMASK)) - 32'd1 & 32'(CMASK);
			end
		end
	end

	// control sequencer
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		out_valid = (state_q == S_OUT);
		unique case (state_q)
			S_IDLE: if (not_empty) begin
				pop = 1'b1;
				state_d = entry.keep ? S_BITS : (entry.last ? S_CALC : S_IDLE);
			end
			S_BITS: if (bidx_q == 3'd0)
				state_d = last_q ? S_CALC : S_IDLE;
			S_CALC: state_d = (ph_q == hsps_pkg::PH_DONE_TIMED && tick_q != 32'd0)
				? S_DIV : S_OUT;
			S_DIV: if (div_cnt_q == 6'd0) state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// byte register
	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q <= entry.data;
			last_q <= entry.last;
			bidx_q <= 3'd7;
		end else if (state_q == S_BITS) begin
			bidx_q <= bidx_q - 3'd1;
		end
	end

	// parse state, datapath and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		logic [8:0]  lend;
		logic [7:0]  dlt, lc;
		logic [32:0] sum;
		logic [20:0] w, h, sh, sv;
		logic [33:0] subh, subv;
		if (!arst_n) begin
			ph_q <= hsps_pkg::PH_HDR;
			bit_counter_q <= '0;
			golomb_zeros_q <= '0;
			field_accum_q <= '0;
			loop_counter_q <= '0;
			scale_last_q <= 8'd8;
			scale_next_q <= 8'd8;
			width_mbs_q <= '0;
			height_units_q <= '0;
			crop_h_q <= '0;
			crop_v_q <= '0;
			frame_only_q <= 1'b1;
			tick_q <= '0;
			scale_q <= '0;
			profile_level_q <= '0;
			div_cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			pic_width <= '0;
			pic_height <= '0;
			profile_code <= '0;
			level_code <= '0;
			frame_rate <= '0;
			timing_present <= 1'b0;
			parse_status <= '0;
		end else if (take) begin
			if (fin) begin
				// field complete: clear the accumulator and advance the syntax walk
				field_accum_q <= '0;
				bit_counter_q <= '0;
				golomb_zeros_q <= '0;
				lend = '0; dlt = '0; lc = '0; sum = '0;
				unique case (ph_q)
					hsps_pkg::PH_HDR: ph_q <= hsps_pkg::PH_PROF;
					hsps_pkg::PH_PROF: begin
						profile_level_q[15:8] <= fin_v[7:0];
						ph_q <= hsps_pkg::PH_CONS;
					end
					hsps_pkg::PH_CONS: ph_q <= hsps_pkg::PH_LEVEL;
					hsps_pkg::PH_LEVEL: begin
						profile_level_q[7:0] <= fin_v[7:0];
						ph_q <= hsps_pkg::PH_SPSID;
					end
					hsps_pkg::PH_SPSID: ph_q <= hsps_pkg::high_profile(profile_level_q[15:8])
						? hsps_pkg::PH_CHROMA : hsps_pkg::PH_LOG2FN;
					hsps_pkg::PH_CHROMA: ph_q <= (fin_v == 32'd3)
						? hsps_pkg::PH_RESID : hsps_pkg::PH_BDL;
					hsps_pkg::PH_RESID: ph_q <= hsps_pkg::PH_BDL;
					hsps_pkg::PH_BDL: ph_q <= hsps_pkg::PH_BDC;
					hsps_pkg::PH_BDC: ph_q <= hsps_pkg::PH_BYPASS;
					hsps_pkg::PH_BYPASS: ph_q <= hsps_pkg::PH_SMP;
					hsps_pkg::PH_SMP: begin
						loop_counter_q <= '0;
						ph_q <= fin_v[0] ? hsps_pkg::PH_LISTFLAG : hsps_pkg::PH_LOG2FN;
					end
					hsps_pkg::PH_LISTFLAG: begin
						if (fin_v[0]) begin
							scale_last_q <= 8'd8;
							scale_next_q <= 8'd8;
							ph_q <= hsps_pkg::PH_DELTA;
						end else begin
							lend = hsps_pkg::list_end(loop_counter_q);
							loop_counter_q <= lend[7:0];
							ph_q <= (lend[7:0] >= hsps_pkg::LIST_LIMIT)
								? hsps_pkg::PH_LOG2FN : hsps_pkg::PH_LISTFLAG;
						end
					end
					hsps_pkg::PH_DELTA: begin
						dlt = fin_v[0] ? fin_v[8:1] + 8'd1 : 8'd0 - fin_v[8:1];
						dlt = dlt + scale_last_q;
						scale_next_q <= dlt;
						if (dlt != 8'd0)
							scale_last_q <= dlt;
						lend = hsps_pkg::list_end(loop_counter_q);
						lc = (dlt == 8'd0) ? lend[7:0] : loop_counter_q + 8'd1;
						loop_counter_q <= lc;
						if (lc >= hsps_pkg::LIST_LIMIT)
							ph_q <= hsps_pkg::PH_LOG2FN;
						else if ({1'b0, lc} == lend)
							ph_q <= hsps_pkg::PH_LISTFLAG;
						else
							ph_q <= hsps_pkg::PH_DELTA;
					end
					hsps_pkg::PH_LOG2FN: ph_q <= hsps_pkg::PH_POCTYPE;
					hsps_pkg::PH_POCTYPE: ph_q <= (fin_v == 32'd0) ? hsps_pkg::PH_LOG2POC
						: (fin_v == 32'd1) ? hsps_pkg::PH_DPAZ : hsps_pkg::PH_MAXREF;
					hsps_pkg::PH_LOG2POC: ph_q <= hsps_pkg::PH_MAXREF;
					hsps_pkg::PH_DPAZ: ph_q <= hsps_pkg::PH_ONRP;
					hsps_pkg::PH_ONRP: ph_q <= hsps_pkg::PH_OTTB;
					hsps_pkg::PH_OTTB: ph_q <= hsps_pkg::PH_NCYCLE;
					hsps_pkg::PH_NCYCLE: begin
						lc = (fin_v > 32'd255) ? 8'd255 : fin_v[7:0];
						loop_counter_q <= lc;
						ph_q <= (lc != 8'd0) ? hsps_pkg::PH_OFFREF : hsps_pkg::PH_MAXREF;
					end
					hsps_pkg::PH_OFFREF: begin
						lc = loop_counter_q - 8'd1;
						loop_counter_q <= lc;
						ph_q <= (lc != 8'd0) ? hsps_pkg::PH_OFFREF : hsps_pkg::PH_MAXREF;
					end
					hsps_pkg::PH_MAXREF: ph_q <= hsps_pkg::PH_GAPS;
					hsps_pkg::PH_GAPS: ph_q <= hsps_pkg::PH_WIDTH;
					hsps_pkg::PH_WIDTH: begin
						width_mbs_q <= (fin_v >= 32'd65535) ? 16'hFFFF : fin_v[15:0] + 16'd1;
						ph_q <= hsps_pkg::PH_HEIGHT;
					end
					hsps_pkg::PH_HEIGHT: begin
						height_units_q <= (fin_v >= 32'd65535) ? 16'hFFFF
							: fin_v[15:0] + 16'd1;
						ph_q <= hsps_pkg::PH_FMO;
					end
					hsps_pkg::PH_FMO: begin
						frame_only_q <= fin_v[0];
						ph_q <= fin_v[0] ? hsps_pkg::PH_DIRECT : hsps_pkg::PH_MBAFF;
					end
					hsps_pkg::PH_MBAFF: ph_q <= hsps_pkg::PH_DIRECT;
					hsps_pkg::PH_DIRECT: ph_q <= hsps_pkg::PH_CROPF;
					hsps_pkg::PH_CROPF: ph_q <= fin_v[0] ? hsps_pkg::PH_CROPL
						: hsps_pkg::PH_VUI;
					hsps_pkg::PH_CROPL, hsps_pkg::PH_CROPR: begin
						sum = {1'b0, crop_h_q} + {1'b0, fin_v};
						crop_h_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						ph_q <= (ph_q == hsps_pkg::PH_CROPL) ? hsps_pkg::PH_CROPR
							: hsps_pkg::PH_CROPT;
					end
					hsps_pkg::PH_CROPT, hsps_pkg::PH_CROPB: begin
						sum = {1'b0, crop_v_q} + {1'b0, fin_v};
						crop_v_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						ph_q <= (ph_q == hsps_pkg::PH_CROPT) ? hsps_pkg::PH_CROPB
							: hsps_pkg::PH_VUI;
					end
					hsps_pkg::PH_VUI: ph_q <= fin_v[0] ? hsps_pkg::PH_ARFLAG
						: hsps_pkg::PH_DONE;
					hsps_pkg::PH_ARFLAG: ph_q <= fin_v[0] ? hsps_pkg::PH_ARIDC
						: hsps_pkg::PH_OVFLAG;
					hsps_pkg::PH_ARIDC: ph_q <= (fin_v == 32'd255) ? hsps_pkg::PH_SARW
						: hsps_pkg::PH_OVFLAG;
					hsps_pkg::PH_SARW: ph_q <= hsps_pkg::PH_SARH;
					hsps_pkg::PH_SARH: ph_q <= hsps_pkg::PH_OVFLAG;
					hsps_pkg::PH_OVFLAG: ph_q <= fin_v[0] ? hsps_pkg::PH_OVAPP
						: hsps_pkg::PH_VSFLAG;
					hsps_pkg::PH_OVAPP: ph_q <= hsps_pkg::PH_VSFLAG;
					hsps_pkg::PH_VSFLAG: ph_q <= fin_v[0] ? hsps_pkg::PH_VFMT
						: hsps_pkg::PH_CLFLAG;
					hsps_pkg::PH_VFMT: ph_q <= hsps_pkg::PH_FULLR;
					hsps_pkg::PH_FULLR: ph_q <= hsps_pkg::PH_CDFLAG;
					hsps_pkg::PH_CDFLAG: ph_q <= fin_v[0] ? hsps_pkg::PH_CPRIM
						: hsps_pkg::PH_CLFLAG;
					hsps_pkg::PH_CPRIM: ph_q <= hsps_pkg::PH_TRANS;
					hsps_pkg::PH_TRANS: ph_q <= hsps_pkg::PH_MATRIX;
					hsps_pkg::PH_MATRIX: ph_q <= hsps_pkg::PH_CLFLAG;
					hsps_pkg::PH_CLFLAG: ph_q <= fin_v[0] ? hsps_pkg::PH_CLTOP
						: hsps_pkg::PH_TIMFLAG;
					hsps_pkg::PH_CLTOP: ph_q <= hsps_pkg::PH_CLBOT;
					hsps_pkg::PH_CLBOT: ph_q <= hsps_pkg::PH_TIMFLAG;
					hsps_pkg::PH_TIMFLAG: ph_q <= fin_v[0] ? hsps_pkg::PH_TICK
						: hsps_pkg::PH_DONE;
					hsps_pkg::PH_TICK: begin
						tick_q <= fin_v;
						ph_q <= hsps_pkg::PH_SCALE;
					end
					hsps_pkg::PH_SCALE: begin
						scale_q <= fin_v;
						ph_q <= hsps_pkg::PH_DONE_TIMED;
					end
					default: ph_q <= ph_q;
				endcase
			end else if (flen != 6'd0) begin
				// accumulate bits of a fixed-width field
				field_accum_q <= acc_sh;
				bit_counter_q <= bit_counter_q + 6'd1;
			end else if (bit_counter_q == 6'd0) begin
				// count leading zeros, then load the implicit leading one
				if (!bit_in) begin
					if (golomb_zeros_q < 6'd63)
						golomb_zeros_q <= golomb_zeros_q + 6'd1;
				end else if (golomb_zeros_q != 6'd0) begin
					bit_counter_q <= golomb_zeros_q;
					field_accum_q <= 32'd1;
				end
			end else begin
				field_accum_q <= acc_sh & 32'(CMASK);
				bit_counter_q <= bit_counter_q - 6'd1;
			end
		end else if (state_q == S_CALC) begin
			// sizes: crop unit 2, floor 0, ceiling 65535
			w = {1'b0, width_mbs_q, 4'b0};
			h = frame_only_q ? {1'b0, height_units_q, 4'b0} : {height_units_q, 5'b0};
			subh = {1'b0, crop_h_q, 1'b0};
			subv = {1'b0, crop_v_q, 1'b0};
			sh = w - subh[20:0];
			sv = h - subv[20:0];
			pic_width <= (subh >= {13'd0, w}) ? 16'd0 : (sh > 21'd65535) ? 16'hFFFF
				: sh[15:0];
			pic_height <= (subv >= {13'd0, h}) ? 16'd0 : (sv > 21'd65535) ? 16'hFFFF
				: sv[15:0];
			profile_code <= profile_level_q[15:8];
			level_code <= profile_level_q[7:0];
			timing_present <= (ph_q == hsps_pkg::PH_DONE_TIMED);
			frame_rate <= '0;
			if (ph_q < hsps_pkg::PH_VUI)
				parse_status <= hsps_pkg::ST_SHORT;
			else if (ph_q == hsps_pkg::PH_DONE_TIMED && tick_q == 32'd0)
				parse_status <= hsps_pkg::ST_ZERO_TICK;
			else
				parse_status <= hsps_pkg::ST_OK;
			rem_q <= '0;
			quo_q <= scale_q;
			div_cnt_q <= 6'd31;
		end else if (state_q == S_DIV) begin
			// restoring division, one quotient bit per cycle
			sum = {rem_q[31:0], quo_q[31]};
			if ({1'b0, sum} >= {1'b0, divisor}) begin
				rem_q <= sum - divisor;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= sum;
				quo_q <= {quo_q[30:0], 1'b0};
			end
			if (div_cnt_q == 6'd0)
				frame_rate <= {quo_q[30:0], ({1'b0, sum} >= {1'b0, divisor})};
			else
				div_cnt_q <= div_cnt_q - 6'd1;
		end else if (state_q == S_OUT && out_ready) begin
			// back to reset state for the next unit
			ph_q <= hsps_pkg::PH_HDR;
			bit_counter_q <= '0;
			golomb_zeros_q <= '0;
			field_accum_q <= '0;
			loop_counter_q <= '0;
			scale_last_q <= 8'd8;
			scale_next_q <= 8'd8;
			width_mbs_q <= '0;
			height_units_q <= '0;
			crop_h_q <= '0;
			crop_v_q <= '0;
			frame_only_q <= 1'b1;
			tick_q <= '0;
			scale_q <= '0;
			profile_level_q <= '0;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/h264_sps_size_rate_parser.sv
`default_nettype none
// H.264 sequence parameter set parser. Bytes of one SPS NAL unit (header
// first) enter on in_valid/in_ready; emulation prevention bytes are dropped
// and the fields are decoded one bit per clock while a kept byte is held; a
// kept byte is taken from the queue and then its eight bits are parsed, a
// dropped byte only taken from the queue. On the byte marked last the block
// gives one result on out_valid/out_ready: cropped width and height (crop
// unit 2, saturated), profile, level and frame rate. The result is presented
// after the compute step, then bit-serial division if timing is present with
// a nonzero tick; the parser returns to idle on the result transfer and then
// takes the next byte. A two-entry queue lets the byte front end run ahead.
module h264_sps_size_rate_parser #(
	parameter int CODE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      pic_width,
	output logic [15:0]      pic_height,
	output logic [7:0]       profile_code,
	output logic [7:0]       level_code,
	output logic [31:0]      frame_rate,
	output logic             timing_present,
	output logic [1:0]       parse_status
);
	logic             push, full, pop, not_empty;
	hsps_pkg::entry_t push_entry, pop_entry;

	hsps_front u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .data_byte,
		.last_byte, .push, .push_entry, .full
	);

	hsps_fifo u_fifo (
		.clk, .arst_n, .push, .push_entry, .full, .pop, .pop_entry, .not_empty
	);

	hsps_parse #(.CODE_BITS(CODE_BITS)) u_parse (
		.clk, .arst_n, .entry(pop_entry), .not_empty, .pop, .out_valid,
		.out_ready, .pic_width, .pic_height, .profile_code, .level_code,
		.frame_rate, .timing_present, .parse_status
	);
endmodule
`default_nettype wire
